// File: design/cursor_linked_list_engine_macros.svh
// ----------------------------------------------------------------------------
// Cursor linked list engine assertion macros
// Wrappers for concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define CLLE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed");
// Check an implication on every rising clock edge outside reset.
`define CLLE_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("implication check failed");
`else
`define CLLE_ASSERT(label, clk, rst, prop)
`define CLLE_ASSERT_IMP(label, clk, rst, cond, prop)
`endif
`endif

// File: design/clle_pkg.sv
// ----------------------------------------------------------------------------
// Cursor linked list engine package
// Op codes, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package clle_pkg;

   localparam int CAPACITY_DEF   = 256;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int OP_W           = 4;
   localparam int STATUS_W       = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR      = 4'd0,
      OP_HEAD       = 4'd1,
      OP_END        = 4'd2,
      OP_NEXT       = 4'd3,
      OP_PREV       = 4'd4,
      OP_READ       = 4'd5,
      OP_REMOVE     = 4'd6,
      OP_INSLEFT    = 4'd7,
      OP_INSRIGHT   = 4'd8,
      OP_APPENDEND  = 4'd9,
      OP_APPENDHEAD = 4'd10,
      OP_SEARCH     = 4'd11
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE       = 2'd0,
      ST_CURSOR_OUT = 2'd1,
      ST_FULL       = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LINK,
      S_INS_LINK,
      S_SEARCH,
      S_RESP
   } state_type;

endpackage

// File: design/clle_if.sv
// ----------------------------------------------------------------------------
// Cursor linked list engine channels
// Valid/ready channels for op requests and op responses.
// ----------------------------------------------------------------------------
interface clle_req_if #(parameter int DATA_WIDTH = clle_pkg::DATA_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic [clle_pkg::OP_W-1:0]     op;
   logic [DATA_WIDTH-1:0]         data_value;

   modport source (output valid, op, data_value, input ready);
   modport sink   (input valid, op, data_value, output ready);
endinterface

interface clle_rsp_if #(parameter int DATA_WIDTH = clle_pkg::DATA_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic [DATA_WIDTH-1:0]         read_value;
   logic                          read_valid;
   logic                          found;
   logic [clle_pkg::STATUS_W-1:0] status;
   logic                          list_empty;
   logic                          cursor_out;

   modport source (output valid, read_value, read_valid, found, status, list_empty,
                   cursor_out, input ready);
   modport sink   (input valid, read_value, read_valid, found, status, list_empty,
                   cursor_out, output ready);
endinterface

// File: design/cursor_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Cursor linked list engine
// Circular doubly linked list with a cursor, held in link memories.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one op per transaction (op, data_value); rsp_ch returns
//   exactly one response transaction per op, in order.
//   Sequencer states from accepted request to response register:
//     S_RESP                     : clear, head, end, undefined codes, dropped ops
//     S_LINK, S_RESP             : next, prev, read, remove
//     S_LINK, S_INS_LINK, S_RESP : insert and append
//     S_SEARCH per entry, S_RESP : search
//   One op is in work at a time; the next request is taken in the cycle
//   after the response is loaded. The search walk visits one entry per
//   cycle, the next address coming straight from the registered link read.
//   Entry 0 (the sentinel) lives in head/tail registers; all other links,
//   payloads and the free stack live in simple dual port memories with a
//   registered read. Unused free stack entries below a low-water mark are
//   generated, so reset and clear need no sweep of the stack.
//   When rsp_ch stalls, the finished response holds in the sequencer and
//   req_ch is not ready until the output register drains.
// ----------------------------------------------------------------------------
`include "cursor_linked_list_engine_macros.svh"

module cursor_linked_list_engine #(
   parameter int CAPACITY   = clle_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = clle_pkg::DATA_WIDTH_DEF
) (
   input logic             clock,
   input logic             reset,
   clle_req_if.sink        req_ch,
   clle_rsp_if.source      rsp_ch
);

   localparam int SLOT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam logic [SLOT_W-1:0] CAP_SLOT = SLOT_W'(CAPACITY);
   localparam logic [SLOT_W-1:0] NIL      = '0;

   // Memories
   logic [SLOT_W-1:0]     next_mem [CAPACITY+1];
   logic [SLOT_W-1:0]     prev_mem [CAPACITY+1];
   logic [DATA_WIDTH-1:0] pay_mem  [CAPACITY+1];
   logic [SLOT_W-1:0]     free_mem [CAPACITY];

   // Read side
   logic [SLOT_W-1:0]     rd_addr;
   logic [IDX_W-1:0]      free_rd_idx;
   logic [SLOT_W-1:0]     next_rd, prev_rd, free_rd;
   logic [DATA_WIDTH-1:0] pay_rd;

   // Write side
   logic                  next_we, prev_we, pay_we, free_we;
   logic [SLOT_W-1:0]     next_wa, prev_wa, next_wd, prev_wd;
   logic [IDX_W-1:0]      free_wa;
   logic [SLOT_W-1:0]     free_wd;

   // Control state
   clle_pkg::state_type   state_ff, state_in;
   logic [SLOT_W-1:0]     head_ff, head_in, tail_ff, tail_in;
   logic [SLOT_W-1:0]     cursor_ff, cursor_in;
   logic [SLOT_W-1:0]     free_cnt_ff, free_cnt_in;
   logic [SLOT_W-1:0]     low_ff, low_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Op context
   clle_pkg::op_type      op_ff, op_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [SLOT_W-1:0]     walk_ff, walk_in;
   logic                  fresh_ff, fresh_in;
   logic [SLOT_W-1:0]     fresh_val_ff, fresh_val_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in, lft_ff, lft_in, rgt_ff, rgt_in;

   // Pending result and output register
   logic [DATA_WIDTH-1:0] res_rv_ff, res_rv_in;
   logic                  res_rvalid_ff, res_rvalid_in, res_found_ff, res_found_in;
   logic [clle_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [DATA_WIDTH-1:0] out_rv_ff, out_rv_in;
   logic                  out_rvalid_ff, out_rvalid_in, out_found_ff, out_found_in;
   logic [clle_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic                  out_empty_ff, out_empty_in, out_cout_ff, out_cout_in;

   // Combinational helpers
   clle_pkg::op_type      req_op;
   logic                  req_fire, list_empty;
   logic [SLOT_W-1:0]     ins_cursor, pop_cnt, new_slot;

   assign req_op     = clle_pkg::op_type'(req_ch.op);
   assign req_ch.ready = (state_ff == clle_pkg::S_IDLE);
   assign req_fire   = req_ch.valid && req_ch.ready;
   assign list_empty = (head_ff == NIL);
   assign pop_cnt    = free_cnt_ff - SLOT_W'(1);
   assign free_rd_idx = pop_cnt[IDX_W-1:0];
   assign new_slot   = fresh_ff ? fresh_val_ff : free_rd;

   // Pick the cursor an insert works on: appends move it first
   always_comb begin
      case (req_op)
         clle_pkg::OP_APPENDEND:  ins_cursor = tail_ff;
         clle_pkg::OP_APPENDHEAD: ins_cursor = head_ff;
         default:                 ins_cursor = cursor_ff;
      endcase
   end

   // Read all memories every cycle; read data arrives in the next cycle
   always_ff @(posedge clock) begin
      next_rd <= next_mem[rd_addr];
      prev_rd <= prev_mem[rd_addr];
      pay_rd  <= pay_mem[rd_addr];
      free_rd <= free_mem[free_rd_idx];
   end

   // Write ports
   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (pay_we)  pay_mem[slot_in]  <= data_ff;
      if (free_we) free_mem[free_wa] <= free_wd;
   end

   // Sequencer: next state, memory accesses and results
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cursor_in     = cursor_ff;
      free_cnt_in   = free_cnt_ff;
      low_in        = low_ff;
      op_in         = op_ff;
      data_in       = data_ff;
      walk_in       = walk_ff;
      fresh_in      = fresh_ff;
      fresh_val_in  = fresh_val_ff;
      slot_in       = slot_ff;
      lft_in        = lft_ff;
      rgt_in        = rgt_ff;
      res_rv_in     = res_rv_ff;
      res_rvalid_in = res_rvalid_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rd_addr       = cursor_ff;
      next_we = 1'b0; next_wa = NIL; next_wd = NIL;
      prev_we = 1'b0; prev_wa = NIL; prev_wd = NIL;
      pay_we  = 1'b0;
      free_we = 1'b0; free_wa = free_cnt_ff[IDX_W-1:0]; free_wd = cursor_ff;

      unique case (state_ff)
         clle_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in         = req_op;
               data_in       = req_ch.data_value;
               res_rv_in     = '0;
               res_rvalid_in = 1'b0;
               res_found_in  = 1'b0;
               res_status_in = clle_pkg::ST_DONE;
               state_in      = clle_pkg::S_RESP;
               case (req_op) inside
                  clle_pkg::OP_CLEAR: begin
                     head_in     = NIL;
                     tail_in     = NIL;
                     cursor_in   = NIL;
                     free_cnt_in = CAP_SLOT;
                     low_in      = CAP_SLOT;
                  end
                  clle_pkg::OP_HEAD: cursor_in = head_ff;
                  clle_pkg::OP_END:  cursor_in = tail_ff;
                  clle_pkg::OP_NEXT, clle_pkg::OP_PREV, clle_pkg::OP_READ,
                  clle_pkg::OP_REMOVE: begin
                     if (cursor_ff == NIL) res_status_in = clle_pkg::ST_CURSOR_OUT;
                     else                  state_in = clle_pkg::S_LINK;
                  end
                  clle_pkg::OP_INSLEFT, clle_pkg::OP_INSRIGHT, clle_pkg::OP_APPENDEND,
                  clle_pkg::OP_APPENDHEAD: begin
                     cursor_in = ins_cursor;
                     rd_addr   = ins_cursor;
                     if (!list_empty && ins_cursor == NIL) begin
                        res_status_in = clle_pkg::ST_CURSOR_OUT;
                     end else if (free_cnt_ff == NIL) begin
                        res_status_in = clle_pkg::ST_FULL;
                     end else begin
                        // pop a slot; below the low mark the stack is untouched
                        free_cnt_in  = pop_cnt;
                        fresh_in     = (pop_cnt < low_ff);
                        fresh_val_in = CAP_SLOT - pop_cnt;
                        if (pop_cnt < low_ff) low_in = pop_cnt;
                        state_in     = clle_pkg::S_LINK;
                     end
                  end
                  clle_pkg::OP_SEARCH: begin
                     walk_in = head_ff;
                     rd_addr = head_ff;
                     if (head_ff == NIL) cursor_in = NIL;
                     else                state_in  = clle_pkg::S_SEARCH;
                  end
                  default: ;
               endcase
            end
         end

         clle_pkg::S_LINK: begin
            state_in = clle_pkg::S_RESP;
            case (op_ff)
               clle_pkg::OP_NEXT: cursor_in = next_rd;
               clle_pkg::OP_PREV: cursor_in = prev_rd;
               clle_pkg::OP_READ: begin
                  res_rv_in     = pay_rd;
                  res_rvalid_in = 1'b1;
               end
               clle_pkg::OP_REMOVE: begin
                  // unlink: prev[n] = p, next[p] = n
                  if (next_rd == NIL) tail_in = prev_rd;
                  else begin
                     prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
                  end
                  if (prev_rd == NIL) head_in = next_rd;
                  else begin
                     next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
                  end
                  cursor_in = prev_rd;
                  if (free_cnt_ff < CAP_SLOT) begin
                     free_we     = 1'b1;
                     free_cnt_in = free_cnt_ff + SLOT_W'(1);
                  end
               end
               default: begin
                  // insert: link the new entry itself
                  if (list_empty) begin
                     lft_in = NIL; rgt_in = NIL;
                  end else if (op_ff == clle_pkg::OP_INSRIGHT ||
                               op_ff == clle_pkg::OP_APPENDEND) begin
                     lft_in = cursor_ff; rgt_in = next_rd;
                  end else begin
                     lft_in = prev_rd; rgt_in = cursor_ff;
                  end
                  slot_in = new_slot;
                  pay_we  = 1'b1;
                  next_we = 1'b1; next_wa = new_slot; next_wd = rgt_in;
                  prev_we = 1'b1; prev_wa = new_slot; prev_wd = lft_in;
                  state_in = clle_pkg::S_INS_LINK;
               end
            endcase
         end

         clle_pkg::S_INS_LINK: begin
            // hook the neighbors to the new entry
            if (lft_ff == NIL) head_in = slot_ff;
            else begin
               next_we = 1'b1; next_wa = lft_ff; next_wd = slot_ff;
            end
            if (rgt_ff == NIL) tail_in = slot_ff;
            else begin
               prev_we = 1'b1; prev_wa = rgt_ff; prev_wd = slot_ff;
            end
            cursor_in = slot_ff;
            state_in  = clle_pkg::S_RESP;
         end

         clle_pkg::S_SEARCH: begin
            if (pay_rd == data_ff) begin
               res_found_in = 1'b1;
               cursor_in    = walk_ff;
               state_in     = clle_pkg::S_RESP;
            end else if (next_rd == NIL) begin
               cursor_in = NIL;
               state_in  = clle_pkg::S_RESP;
            end else begin
               walk_in = next_rd;
               rd_addr = next_rd;
            end
         end

         clle_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = clle_pkg::S_IDLE;
         end

         default: state_in = clle_pkg::S_IDLE;
      endcase
   end

   // Load the output register when the response leaves the sequencer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      out_rv_in     = out_rv_ff;
      out_rvalid_in = out_rvalid_ff;
      out_found_in  = out_found_ff;
      out_status_in = out_status_ff;
      out_empty_in  = out_empty_ff;
      out_cout_in   = out_cout_ff;
      if (state_ff == clle_pkg::S_RESP && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in  = 1'b1;
         out_rv_in     = res_rv_ff;
         out_rvalid_in = res_rvalid_ff;
         out_found_in  = res_found_ff;
         out_status_in = res_status_ff;
         out_empty_in  = list_empty;
         out_cout_in   = (cursor_ff == NIL);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clle_pkg::S_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         cursor_ff    <= NIL;
         free_cnt_ff  <= CAP_SLOT;
         low_ff       <= CAP_SLOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         free_cnt_ff  <= free_cnt_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      data_ff       <= data_in;
      walk_ff       <= walk_in;
      fresh_ff      <= fresh_in;
      fresh_val_ff  <= fresh_val_in;
      slot_ff       <= slot_in;
      lft_ff        <= lft_in;
      rgt_ff        <= rgt_in;
      res_rv_ff     <= res_rv_in;
      res_rvalid_ff <= res_rvalid_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      out_rv_ff     <= out_rv_in;
      out_rvalid_ff <= out_rvalid_in;
      out_found_ff  <= out_found_in;
      out_status_ff <= out_status_in;
      out_empty_ff  <= out_empty_in;
      out_cout_ff   <= out_cout_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = out_rv_ff;
   assign rsp_ch.read_valid = out_rvalid_ff;
   assign rsp_ch.found      = out_found_ff;
   assign rsp_ch.status     = out_status_ff;
   assign rsp_ch.list_empty = out_empty_ff;
   assign rsp_ch.cursor_out = out_cout_ff;

   // Checks
   `CLLE_ASSERT_IMP(a_empty_all_free, clock, reset, state_ff == clle_pkg::S_IDLE,
      (head_ff == NIL) == (free_cnt_ff == CAP_SLOT))
   `CLLE_ASSERT_IMP(a_cursor_needs_list, clock, reset, state_ff == clle_pkg::S_IDLE,
      cursor_ff == NIL || head_ff != NIL)
   `CLLE_ASSERT(a_low_mark, clock, reset, low_ff <= free_cnt_ff && free_cnt_ff <= CAP_SLOT)

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor linked list engine testbench
// Drives list ops with random gaps, predicts each response with a model of
// the list kept in arrays, and checks every response in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CAP = clle_pkg::CAPACITY_DEF;
   localparam int DW  = clle_pkg::DATA_WIDTH_DEF;

   typedef struct packed {
      logic [DW-1:0] read_value;
      logic          read_valid;
      logic          found;
      logic [1:0]    status;
      logic          list_empty;
      logic          cursor_out;
   } list_rsp_type;

   // Scoreboard: own list model and queue of pending responses
   class list_scoreboard;
      logic [8:0]    nxt [0:CAP];
      logic [8:0]    prv [0:CAP];
      logic [DW-1:0] val [0:CAP];
      logic [8:0]    free_stk [0:CAP-1];
      int            free_n;
      logic [8:0]    cur;
      list_rsp_type  pending [$];
      int            errors;
      int            entries;

      function void wipe();
         nxt[0] = 0; prv[0] = 0;
         for (int i = 0; i < CAP; i++) free_stk[i] = 9'(CAP - i);
         free_n = CAP; cur = 0; entries = 0;
      endfunction

      function logic [1:0] insert(logic [DW-1:0] v, bit right);
         bit empty;
         logic [8:0] s, l, r;
         empty = (nxt[0] == 0);
         if (!empty && cur == 0) return clle_pkg::ST_CURSOR_OUT;
         if (free_n == 0) return clle_pkg::ST_FULL;
         free_n--;
         s = free_stk[free_n];
         val[s] = v;
         if (empty) begin
            l = 0; r = 0;
         end else if (right) begin
            l = cur; r = nxt[cur];
         end else begin
            l = prv[cur]; r = cur;
         end
         prv[s] = l; nxt[s] = r; nxt[l] = s; prv[r] = s;
         cur = s; entries++;
         return clle_pkg::ST_DONE;
      endfunction

      // Note an accepted op and queue its predicted response
      function void note_op(logic [3:0] op, logic [DW-1:0] v);
         list_rsp_type e;
         logic [8:0] c;
         e = '0;
         case (op) inside
            clle_pkg::OP_CLEAR: wipe();
            clle_pkg::OP_HEAD:  cur = nxt[0];
            clle_pkg::OP_END:   cur = prv[0];
            clle_pkg::OP_NEXT, clle_pkg::OP_PREV: begin
               if (cur == 0) e.status = clle_pkg::ST_CURSOR_OUT;
               else cur = (op == clle_pkg::OP_NEXT) ? nxt[cur] : prv[cur];
            end
            clle_pkg::OP_READ: begin
               if (cur == 0) e.status = clle_pkg::ST_CURSOR_OUT;
               else begin
                  e.read_value = val[cur]; e.read_valid = 1;
               end
            end
            clle_pkg::OP_REMOVE: begin
               if (cur == 0) e.status = clle_pkg::ST_CURSOR_OUT;
               else begin
                  c = cur;
                  prv[nxt[c]] = prv[c];
                  nxt[prv[c]] = nxt[c];
                  cur = prv[c];
                  entries--;
                  if (free_n < CAP) begin
                     free_stk[free_n] = c; free_n++;
                  end
               end
            end
            clle_pkg::OP_INSLEFT:  e.status = insert(v, 0);
            clle_pkg::OP_INSRIGHT: e.status = insert(v, 1);
            clle_pkg::OP_APPENDEND: begin
               cur = prv[0]; e.status = insert(v, 1);
            end
            clle_pkg::OP_APPENDHEAD: begin
               cur = nxt[0]; e.status = insert(v, 0);
            end
            clle_pkg::OP_SEARCH: begin
               c = nxt[0];
               while (c != 0) begin
                  if (val[c] == v) begin
                     e.found = 1; break;
                  end
                  c = nxt[c];
               end
               cur = c;
            end
            default: ;
         endcase
         e.list_empty = (nxt[0] == 0);
         e.cursor_out = (cur == 0);
         pending.push_back(e);
      endfunction

      // Check one response against the oldest prediction
      function void check_rsp(list_rsp_type got);
         list_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected response: actual %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.read_value !== e.read_value) begin
            $display("%0t read_value: expected %h actual %h", $time, e.read_value,
                     got.read_value); errors++;
         end
         if (got.read_valid !== e.read_valid) begin
            $display("%0t read_valid: expected %b actual %b", $time, e.read_valid,
                     got.read_valid); errors++;
         end
         if (got.found !== e.found) begin
            $display("%0t found: expected %b actual %b", $time, e.found, got.found);
            errors++;
         end
         if (got.status !== e.status) begin
            $display("%0t status: expected %0d actual %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.list_empty !== e.list_empty) begin
            $display("%0t list_empty: expected %b actual %b", $time, e.list_empty,
                     got.list_empty); errors++;
         end
         if (got.cursor_out !== e.cursor_out) begin
            $display("%0t cursor_out: expected %b actual %b", $time, e.cursor_out,
                     got.cursor_out); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   bit   calm  = 0;
   list_scoreboard board = new();

   clle_req_if #(.DATA_WIDTH(DW)) req_ch ();
   clle_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   cursor_linked_list_engine #(.CAPACITY(CAP), .DATA_WIDTH(DW)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.op = '0;
      req_ch.data_value = '0;
      rsp_ch.ready = 0;
   end

   // Response side: sample at the rising edge, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_rsp({rsp_ch.read_value, rsp_ch.read_valid, rsp_ch.found,
                          rsp_ch.status, rsp_ch.list_empty, rsp_ch.cursor_out});
   end

   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 19);
            rsp_ch.ready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1;
         @(negedge clock);
      end
   end

   // Send one op transaction, with an optional idle burst first
   task automatic send_op(logic [3:0] op, logic [DW-1:0] v);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.op <= op;
      req_ch.data_value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_op(op, v);
      @(negedge clock);
   endtask

   // Values from a small pool so searches hit, with some full-range ones
   function automatic logic [DW-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return DW'($urandom_range(0, 15));
   endfunction

   // Mostly list building and walking; occasional clears and undefined op codes
   function automatic logic [3:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 1) return clle_pkg::OP_CLEAR;
      if (r < 5) return 4'($urandom_range(12, 15));
      if (r < 30) return 4'($urandom_range(clle_pkg::OP_INSLEFT, clle_pkg::OP_APPENDHEAD));
      if (r < 40) return clle_pkg::OP_SEARCH;
      if (r < 50) return clle_pkg::OP_REMOVE;
      if (r < 65) return clle_pkg::OP_READ;
      return 4'($urandom_range(clle_pkg::OP_HEAD, clle_pkg::OP_PREV));
   endfunction

   initial begin
      int waited;
      board.wipe();
      board.errors = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: ops on an empty list, then extremes and each special case
      send_op(clle_pkg::OP_HEAD, '0);
      send_op(clle_pkg::OP_END, '0);
      send_op(clle_pkg::OP_NEXT, '0);
      send_op(clle_pkg::OP_PREV, '0);
      send_op(clle_pkg::OP_READ, '0);
      send_op(clle_pkg::OP_REMOVE, '0);
      send_op(clle_pkg::OP_SEARCH, '0);
      send_op(clle_pkg::OP_INSRIGHT, '1);
      send_op(clle_pkg::OP_INSLEFT, '0);
      send_op(clle_pkg::OP_READ, '0);
      send_op(clle_pkg::OP_APPENDEND, 32'h5555_AAAA);
      send_op(clle_pkg::OP_APPENDHEAD, 32'hAAAA_5555);
      send_op(clle_pkg::OP_SEARCH, '1);
      send_op(clle_pkg::OP_NEXT, '0);
      send_op(clle_pkg::OP_READ, '0);
      send_op(clle_pkg::OP_SEARCH, 32'h1234_5678);
      send_op(clle_pkg::OP_INSLEFT, 32'd7);
      send_op(clle_pkg::OP_END, '0);
      send_op(clle_pkg::OP_PREV, '0);
      send_op(clle_pkg::OP_REMOVE, '0);
      send_op(clle_pkg::OP_HEAD, '0);
      send_op(clle_pkg::OP_REMOVE, '0);
      send_op(4'd15, '1);
      send_op(clle_pkg::OP_CLEAR, '0);

      // Fill the store, overflow it, free a few slots, then clear
      for (int i = 0; i < CAP + 3; i++) send_op(clle_pkg::OP_APPENDEND, $urandom);
      send_op(clle_pkg::OP_INSLEFT, '1);
      send_op(clle_pkg::OP_END, '0);
      for (int i = 0; i < 8; i++) send_op(clle_pkg::OP_REMOVE, '0);
      send_op(clle_pkg::OP_APPENDHEAD, 32'd3);
      send_op(clle_pkg::OP_CLEAR, '0);

      // Random ops
      for (int i = 0; i < 350; i++) begin
         if (i == 300) calm = 1;
         send_op(pick_op(), pick_value());
      end
      req_ch.valid <= 0;

      waited = 0;
      while (board.pending.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (1100) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/clle_pkg.sv
design/clle_if.sv
design/cursor_linked_list_engine.sv
sim/tb_top.sv
